>>> sv/stereo_downmix_linear_resampler_assert.svh
// Assertion macros for the downmix resampler checker.
`ifndef STEREO_DOWNMIX_LINEAR_RESAMPLER_ASSERT_SVH
`define STEREO_DOWNMIX_LINEAR_RESAMPLER_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define SDMX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define SDMX_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> sv/sdmx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdmx_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int PHASE_FRAC_BITS = 16;
	localparam int MAX_RUN         = 16;

	localparam int PHASE_BITS    = PHASE_FRAC_BITS + 4;
	localparam int CFG_DATA_BITS = PHASE_BITS;
	localparam int CFG_IDX_BITS  = 1;
	localparam int RUN_BITS      = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
	localparam int DIFF_BITS     = SAMPLE_BITS + 1;
	localparam int PROD_BITS     = DIFF_BITS + PHASE_FRAC_BITS + 1;

	localparam logic [PHASE_BITS-1:0] RATE_RESET = PHASE_BITS'(196608);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_RATE_STEP   = 1'b0,
		REG_PASSTHROUGH = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic accept;
		logic mul;
		logic step;
	} sdmx_cmd_t;

	typedef struct packed {
		logic passthrough;
		logic primed;
		logic phase_ge_one;
		logic last;
	} sdmx_status_t;

endpackage

`default_nettype wire

>>> sv/sdmx_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sdmx_in_if import sdmx_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

>>> sv/sdmx_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sdmx_out_if import sdmx_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] mono_out;
	logic                          last_of_run;

	modport source (output valid, output mono_out, output last_of_run, input ready);
	modport sink (input valid, input mono_out, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> sv/sdmx_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sdmx_ctrl import sdmx_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire logic         out_ready,
	output sdmx_cmd_t         cmd,
	input  wire sdmx_status_t status
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_ADD  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign accept    = in_ready && in_valid;

	always_comb begin
		cmd        = '0;
		cmd.accept = accept;
		state_d    = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (status.passthrough) begin
						state_d = ST_OUT;
					end else if (status.primed && !status.phase_ge_one) begin
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.step = 1'b1;
				state_d  = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) begin
					state_d = status.last ? ST_IDLE : ST_MUL;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> sv/sdmx_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sdmx_datapath import sdmx_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sdmx_cmd_t                     cmd,
	output sdmx_status_t                       status,
	input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
	input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]      cfg_wdata,
	output logic signed [SAMPLE_BITS-1:0]      mono_out,
	output logic                               last_of_run
);

	localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(1) << PHASE_FRAC_BITS;

	logic [PHASE_BITS-1:0]         rate_q;
	logic                          pass_q;
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic signed [SAMPLE_BITS-1:0] cur_q;
	logic [PHASE_BITS-1:0]         phase_q;
	logic                          primed_q;
	logic [RUN_BITS-1:0]           run_q;
	logic signed [PROD_BITS-1:0]   prod_s1;
	logic signed [SAMPLE_BITS-1:0] out_q;
	logic                          last_q;

	logic signed [SAMPLE_BITS:0]   pair_sum;
	logic signed [SAMPLE_BITS-1:0] cur;
	logic signed [DIFF_BITS-1:0]   diff;
	logic signed [PHASE_FRAC_BITS:0] frac;
	logic signed [PROD_BITS-1:0]   scaled;
	logic [PHASE_BITS:0]           phase_sum;
	logic [PHASE_BITS-1:0]         phase_next;
	logic                          next_ge_one;
	logic                          run_last;

	// floor average of the pair
	assign pair_sum = {left_sample[SAMPLE_BITS-1], left_sample}
		+ {right_sample[SAMPLE_BITS-1], right_sample};
	assign cur      = pair_sum[SAMPLE_BITS:1];

	assign diff   = {cur_q[SAMPLE_BITS-1], cur_q} - {prev_q[SAMPLE_BITS-1], prev_q};
	assign frac   = {1'b0, phase_q[PHASE_FRAC_BITS-1:0]};
	assign scaled = prod_s1 >>> PHASE_FRAC_BITS;

	// saturating phase advance
	assign phase_sum   = {1'b0, phase_q} + {1'b0, rate_q};
	assign phase_next  = phase_sum[PHASE_BITS] ? '1 : phase_sum[PHASE_BITS-1:0];
	assign next_ge_one = |phase_next[PHASE_BITS-1:PHASE_FRAC_BITS];
	assign run_last    = next_ge_one || (run_q == RUN_BITS'(MAX_RUN - 1));

	assign status.passthrough  = pass_q;
	assign status.primed       = primed_q;
	assign status.phase_ge_one = |phase_q[PHASE_BITS-1:PHASE_FRAC_BITS];
	assign status.last         = last_q;

	assign mono_out    = out_q;
	assign last_of_run = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= RATE_RESET;
			pass_q   <= 1'b0;
			prev_q   <= '0;
			phase_q  <= '0;
			primed_q <= 1'b0;
			run_q    <= '0;
			last_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RATE_STEP:   rate_q <= cfg_wdata[PHASE_BITS-1:0];
					REG_PASSTHROUGH: pass_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				run_q <= '0;
				if (pass_q) begin
					prev_q   <= cur;
					primed_q <= 1'b1;
					last_q   <= 1'b1;
				end else if (!primed_q) begin
					prev_q   <= cur;
					primed_q <= 1'b1;
				end else if (status.phase_ge_one) begin
					// no result for this sample
					prev_q  <= cur;
					phase_q <= phase_q - PHASE_ONE;
				end
			end
			if (cmd.step) begin
				run_q  <= run_q + RUN_BITS'(1);
				last_q <= run_last;
				if (run_last) begin
					prev_q  <= cur_q;
					phase_q <= next_ge_one ? phase_next - PHASE_ONE : '0;
				end else begin
					phase_q <= phase_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_q <= cur;
			if (pass_q) begin
				out_q <= cur;
			end
		end
		if (cmd.mul) begin
			prod_s1 <= diff * frac;
		end
		if (cmd.step) begin
			out_q <= prev_q + scaled[SAMPLE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

>>> sv/stereo_downmix_linear_resampler.sv
// Channel    Dir  Payload                          Handshake
// samples    in   left_sample, right_sample        valid/ready
// mono       out  mono_out, last_of_run            valid/ready
// cfg        in   cfg_index, cfg_wdata             cfg_we, no stall
//
// A request is taken in the idle state. When resampling, up to MAX_RUN results
// follow, each through a multiply, an add and an output state. A request with
// no result leaves the block idle; a passthrough request goes straight to the
// output state. Samples are not taken while a result is pending. mono stalls
// hold the output register. arst_n clears state and loads defaults.
`timescale 1ns / 1ps
`default_nettype none

module stereo_downmix_linear_resampler import sdmx_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	sdmx_in_if.sink                       samples,
	sdmx_out_if.source                    mono,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	sdmx_cmd_t    cmd;
	sdmx_status_t status;

	sdmx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (mono.valid),
		.out_ready (mono.ready),
		.cmd       (cmd),
		.status    (status)
	);

	sdmx_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.left_sample  (samples.left_sample),
		.right_sample (samples.right_sample),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.mono_out     (mono.mono_out),
		.last_of_run  (mono.last_of_run)
	);

endmodule

`default_nettype wire

>>> sv/sdmx_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_downmix_linear_resampler_assert.svh"

module sdmx_checker import sdmx_pkg::*; (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic signed [SAMPLE_BITS-1:0] mono_out,
	input wire logic                          last_of_run
);

	`SDMX_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable({mono_out, last_of_run}), "stall changed result")
	`SDMX_NEVER(a_no_overlap, in_ready && out_valid, "sample taken while a result is pending")
	`SDMX_ASSERT(a_run_busy, out_valid && out_ready && !last_of_run |=> !in_ready, "ready before the run ended")
	`SDMX_ASSERT(a_run_done, out_valid && out_ready && last_of_run |=> in_ready && !out_valid, "not idle after the last result")
	`SDMX_NEVER(a_out_known, out_valid && $isunknown({mono_out, last_of_run}), "unknown result")

endmodule

bind stereo_downmix_linear_resampler sdmx_checker u_sdmx_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (mono.valid),
	.out_ready   (mono.ready),
	.mono_out    (mono.mono_out),
	.last_of_run (mono.last_of_run)
);

`default_nettype wire

>>> dv/stereo_downmix_linear_resampler_tb.sv
`timescale 1ns / 1ps

module stereo_downmix_linear_resampler_tb;
	import sdmx_pkg::*;

	localparam logic [PHASE_BITS-1:0] UNIT_PHASE = PHASE_BITS'(1) << PHASE_FRAC_BITS;
	localparam logic [PHASE_BITS-1:0] RATE_MAX   = '1;
	localparam int                    SETTLE     = 8;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] mono;
		logic                          last;
	} mono_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	sdmx_in_if  samples();
	sdmx_out_if mono();

	stereo_downmix_linear_resampler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.mono      (mono),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state
	logic [PHASE_BITS-1:0]         rate_q;
	logic                          pass_q;
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic [PHASE_BITS-1:0]         phase_q;
	logic                          primed_q;

	mono_result_t expected_mono[$];
	int           mismatch_count;
	bit           steady;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic void store_expected(input mono_result_t r);
		expected_mono.insert(expected_mono.size(), r);
	endfunction

	function automatic void predict_resampled(input logic signed [SAMPLE_BITS-1:0] l,
						  input logic signed [SAMPLE_BITS-1:0] r);
		logic signed [SAMPLE_BITS:0]   sum;
		logic signed [SAMPLE_BITS-1:0] cur;
		logic [PHASE_BITS:0]           nxt;
		longint                        diff;
		longint                        prod;
		int                            n;
		mono_result_t                  res;
		sum = l + r;
		cur = SAMPLE_BITS'(sum >>> 1);
		n = 0;
		if (pass_q) begin
			res.mono = cur;
			res.last = 1'b1;
			store_expected(res);
			prev_q = cur;
			primed_q = 1'b1;
			return;
		end
		if (!primed_q) begin
			prev_q = cur;
			primed_q = 1'b1;
			return;
		end
		while (phase_q < UNIT_PHASE && n < MAX_RUN) begin
			diff = longint'(cur) - longint'(prev_q);
			prod = diff * longint'(phase_q);
			res.mono = SAMPLE_BITS'(longint'(prev_q) + (prod >>> PHASE_FRAC_BITS));
			res.last = 1'b0;
			store_expected(res);
			n++;
			nxt = {1'b0, phase_q} + {1'b0, rate_q};
			phase_q = nxt[PHASE_BITS] ? RATE_MAX : nxt[PHASE_BITS-1:0];
		end
		if (n > 0)
			expected_mono[expected_mono.size()-1].last = 1'b1;
		if (phase_q >= UNIT_PHASE)
			phase_q = phase_q - UNIT_PHASE;
		else
			phase_q = '0;
		prev_q = cur;
	endfunction

	// result checker
	always @(posedge clk) begin
		mono_result_t want;
		if (arst_n && mono.valid && mono.ready) begin
			if (expected_mono.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", mono.mono_out));
			end else begin
				want = expected_mono[0];
				expected_mono.delete(0);
				if (mono.mono_out !== want.mono)
					report_mismatch($sformatf("mono_out %0d, want %0d",
						mono.mono_out, want.mono));
				if (mono.last_of_run !== want.last)
					report_mismatch($sformatf("last_of_run %0b, want %0b",
						mono.last_of_run, want.last));
			end
		end
	end

	always @(posedge clk) begin
		mono.ready <= steady || ($urandom_range(0, 99) >= 19);
	end

	task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] l,
				 input logic signed [SAMPLE_BITS-1:0] r);
		if (!steady && $urandom_range(0, 99) < 19) begin
			samples.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		samples.valid        <= 1'b1;
		samples.left_sample  <= l;
		samples.right_sample <= r;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
		predict_resampled(l, r);
	endtask

	// drop valid, let every pending result arrive, then let the block settle
	task automatic wait_idle;
		samples.valid <= 1'b0;
		do @(posedge clk); while (expected_mono.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		if (idx == REG_RATE_STEP)
			rate_q = data;
		else
			pass_q = data[0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// defaults after reset; first sample only primes the history
	task automatic test_reset_defaults;
		send_pair(16'sd100, 16'sd200);
		send_pair(-16'sd32768, -16'sd32768);
		send_pair(16'sd32767, 16'sd32767);
		send_pair(-16'sd1, -16'sd2);
	endtask

	task automatic test_passthrough;
		write_reg(REG_PASSTHROUGH, CFG_DATA_BITS'(1));
		send_pair(-16'sd32768, -16'sd32768);
		send_pair(16'sd32767, 16'sd32767);
		send_pair(-16'sd32768, 16'sd32767);
		send_pair(16'sd32767, -16'sd32768);
		send_pair(-16'sd1, 16'sd0);
		send_pair(16'sd1, 16'sd0);
		write_reg(REG_PASSTHROUGH, CFG_DATA_BITS'(0));
	endtask

	// a step under 1/16 hits the run cap and the phase floor at zero, then a step of exactly 1/16 fills the run
	task automatic test_run_cap;
		write_reg(REG_RATE_STEP, CFG_DATA_BITS'(2000));
		send_pair(16'sd32767, 16'sd32767);
		send_pair(-16'sd32768, -16'sd32768);
		send_pair(16'sd1234, -16'sd999);
		write_reg(REG_RATE_STEP, CFG_DATA_BITS'(4096));
		send_pair(16'sd32767, -16'sd1);
		send_pair(-16'sd32768, 16'sd5);
	endtask

	task automatic test_phase_saturation;
		write_reg(REG_RATE_STEP, RATE_MAX);
		send_pair(16'sd500, 16'sd700);
		send_pair(-16'sd300, 16'sd32767);
		send_pair(16'sd32767, 16'sd32767);
		send_pair(-16'sd32768, 16'sd0);
	endtask

	task automatic test_random_streams;
		logic [CFG_DATA_BITS-1:0] rate;
		for (int seg = 0; seg < 7; seg++) begin
			case ($urandom_range(0, 9))
				0: rate = CFG_DATA_BITS'(4096);
				1: rate = RATE_MAX;
				2: rate = UNIT_PHASE;
				default: rate = CFG_DATA_BITS'($urandom_range(4096, 200000));
			endcase
			write_reg(REG_RATE_STEP, rate);
			write_reg(REG_PASSTHROUGH, CFG_DATA_BITS'($urandom_range(0, 4) == 0));
			steady = (seg == 2);
			for (int i = 0; i < 50; i++) begin
				if (seg == 4 && i == 25)
					wait_idle();
				send_pair(pick_sample(), pick_sample());
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		mismatch_count = 0;
		steady         = 1'b0;
		rate_q         = RATE_RESET;
		pass_q         = 1'b0;
		prev_q         = '0;
		phase_q        = '0;
		primed_q       = 1'b0;
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= REG_RATE_STEP;
		cfg_wdata            <= '0;
		samples.valid        <= 1'b0;
		samples.left_sample  <= '0;
		samples.right_sample <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_passthrough();
		test_run_cap();
		test_phase_saturation();
		test_random_streams();

		wait_idle();
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
